@@ design/ist_pkg.sv @@
// Shared constants, codes and scan-unit types for the indexed slot table.
`default_nettype none
package ist_pkg;

  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Slots examined per scan step.
  localparam int CHUNK   = 8;
  localparam int CHUNK_W = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIRST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [CHUNK-1:0] cand;
    logic             down;
  } scan_req_t;

  typedef struct packed {
    logic               found;
    logic [CHUNK_W-1:0] offset;
  } scan_rsp_t;

endpackage
`default_nettype wire

@@ design/ist_if.sv @@
// Request and result channel interfaces of the indexed slot table.
`default_nettype none
interface ist_in_if;
  logic                         valid;
  logic                         ready;
  logic [ist_pkg::CMD_W-1:0]    command;
  logic [ist_pkg::HANDLE_W-1:0] handle_in;
  logic [ist_pkg::DATA_W-1:0]   value_in;

  modport source (output valid, command, handle_in, value_in, input ready);
  modport sink   (input valid, command, handle_in, value_in, output ready);
endinterface

interface ist_out_if;
  logic                         valid;
  logic                         ready;
  logic [ist_pkg::STATUS_W-1:0] status;
  logic [ist_pkg::HANDLE_W-1:0] handle_out;
  logic [ist_pkg::DATA_W-1:0]   data_out;
  logic                         data_valid;
  logic [ist_pkg::COUNT_W-1:0]  used_count;

  modport source (output valid, status, handle_out, data_out, data_valid, used_count,
                  input ready);
  modport sink   (input valid, status, handle_out, data_out, data_valid, used_count,
                  output ready);
endinterface
`default_nettype wire

@@ design/ist_scan.sv @@
// Shared chunk priority encoder: lowest or highest set candidate bit.
`default_nettype none
module ist_scan (
  input  ist_pkg::scan_req_t req,
  output ist_pkg::scan_rsp_t rsp
);

  always_comb begin
    rsp = '0;
    if (req.down) begin
      for (int j = 0; j < ist_pkg::CHUNK; j++) begin
        if (req.cand[j]) begin
          rsp.found  = 1'b1;
          rsp.offset = ist_pkg::CHUNK_W'(j);
        end
      end
    end else begin
      for (int j = ist_pkg::CHUNK - 1; j >= 0; j--) begin
        if (req.cand[j]) begin
          rsp.found  = 1'b1;
          rsp.offset = ist_pkg::CHUNK_W'(j);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/indexed_slot_table.sv @@
// Top level of the indexed slot table: sequencer, occupancy state and word memory.
//
//   channel  | dir | fields                                             | handshake
//   in_ch    | in  | command, handle_in, value_in                       | valid/ready
//   out_ch   | out | status, handle_out, data_out, data_valid, used_count | valid/ready
//
// A request is accepted in the idle state, then runs scan steps, then loads the output.
// Each scan step runs the shared priority encoder over eight slots: allocate, free,
// first and next run scan steps (allocate scans a second time when it wraps
// below the hint); read and error cases skip the scan.
// Reset is synchronous, active low, and empties the table at once.
// A new request is taken while an earlier result waits in the output register; a
// finished result waits in the load state while the output stays stalled.
`default_nettype none
module indexed_slot_table #(
  parameter int SLOTS     = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ist_in_if.sink     in_ch,
  ist_out_if.source  out_ch
);

  localparam int SW     = $clog2(SLOTS);
  localparam int NW     = $clog2(SLOTS + 1);
  localparam int NCHUNK = (SLOTS + ist_pkg::CHUNK - 1) / ist_pkg::CHUNK;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PW     = CW + ist_pkg::CHUNK_W;
  localparam int VPW    = NCHUNK * ist_pkg::CHUNK;
  localparam int CMPW   = (NW > ist_pkg::HANDLE_W) ? NW : ist_pkg::HANDLE_W;
  localparam logic [VPW-1:0] RANGE = {VPW{1'b1}} >> (VPW - SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TRIM = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [SLOTS-1:0]              valid_r, valid_nxt;
  logic [NW-1:0]                 cnt_r, cnt_nxt;
  logic [NW-1:0]                 hint_r, hint_nxt;
  logic [NW-1:0]                 hw_r, hw_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          alloc_r, alloc_nxt;
  logic                          wrapped_r, wrapped_nxt;
  logic [CW-1:0]                 chunk_r, chunk_nxt;
  logic [NW-1:0]                 bound_r, bound_nxt;
  logic [WORD_BITS-1:0]          value_r, value_nxt;
  logic [ist_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [ist_pkg::HANDLE_W-1:0]  res_hout_r, res_hout_nxt;
  logic                          res_dvalid_r, res_dvalid_nxt;

  logic [ist_pkg::STATUS_W-1:0]  out_status_r;
  logic [ist_pkg::HANDLE_W-1:0]  out_hout_r;
  logic [ist_pkg::DATA_W-1:0]    out_data_r;
  logic                          out_dvalid_r;
  logic [ist_pkg::COUNT_W-1:0]   out_cnt_r;

  logic [WORD_BITS-1:0]          words [SLOTS];
  logic [WORD_BITS-1:0]          rd_word_r;
  logic                          wr_en, rd_en;
  logic [SW-1:0]                 wr_addr;

  logic                          in_fire, out_load;
  logic [VPW-1:0]                vpad;
  logic [ist_pkg::CHUNK-1:0]     vchunk, rchunk;
  logic [PW:0]                   pos_j, bound_ext;
  ist_pkg::scan_req_t            scan_req;
  ist_pkg::scan_rsp_t            scan_rsp;
  logic [PW-1:0]                 fidx;
  logic [PW:0]                   fnext;
  logic [NW-1:0]                 fnext_nw;

  logic [CMPW-1:0]               hext, hwext, st;
  logic [ist_pkg::HANDLE_W-1:0]  hm1;
  logic [SW-1:0]                 hidx;
  logic                          h_in_range, h_hit;

  ist_scan u_scan (
    .req (scan_req),
    .rsp (scan_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.handle_out = out_hout_r;
  assign out_ch.data_out   = out_data_r;
  assign out_ch.data_valid = out_dvalid_r;
  assign out_ch.used_count = out_cnt_r;

  // Request decode helpers
  assign hext       = CMPW'(in_ch.handle_in);
  assign hwext      = CMPW'(hw_r);
  assign hm1        = in_ch.handle_in - 1'b1;
  assign hidx       = SW'(hm1);
  assign h_in_range = (in_ch.handle_in != '0) && (hext <= hwext);
  assign h_hit      = h_in_range && valid_r[hidx];

  // Candidate bits of the current chunk
  assign vpad      = VPW'(valid_r);
  assign vchunk    = vpad[chunk_r * ist_pkg::CHUNK +: ist_pkg::CHUNK];
  assign rchunk    = RANGE[chunk_r * ist_pkg::CHUNK +: ist_pkg::CHUNK];
  assign bound_ext = (PW + 1)'(bound_r);

  always_comb begin
    scan_req      = '0;
    pos_j         = '0;
    scan_req.down = (state_r == S_TRIM);
    for (int j = 0; j < ist_pkg::CHUNK; j++) begin
      pos_j = {1'b0, chunk_r, ist_pkg::CHUNK_W'(j)};
      scan_req.cand[j] = rchunk[j]
                       & (scan_req.down ? (pos_j < bound_ext) : (pos_j >= bound_ext))
                       & (alloc_r ? ~vchunk[j] : vchunk[j]);
    end
  end

  assign fidx     = {chunk_r, scan_rsp.offset};
  assign fnext    = {1'b0, fidx} + 1'b1;
  assign fnext_nw = NW'(fnext);

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    hint_nxt       = hint_r;
    hw_nxt         = hw_r;
    out_valid_nxt  = out_valid_r;
    alloc_nxt      = alloc_r;
    wrapped_nxt    = wrapped_r;
    chunk_nxt      = chunk_r;
    bound_nxt      = bound_r;
    value_nxt      = value_r;
    res_status_nxt = res_status_r;
    res_hout_nxt   = res_hout_r;
    res_dvalid_nxt = res_dvalid_r;
    wr_en          = 1'b0;
    wr_addr        = fidx[SW-1:0];
    rd_en          = 1'b0;
    st             = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ist_pkg::ST_OK;
          res_hout_nxt   = '0;
          res_dvalid_nxt = 1'b0;
          alloc_nxt      = 1'b0;
          wrapped_nxt    = 1'b0;
          value_nxt      = WORD_BITS'(in_ch.value_in);
          state_nxt      = S_EMIT;
          unique case (in_ch.command)
            ist_pkg::CMD_ALLOC: begin
              if (cnt_r >= NW'(SLOTS)) begin
                res_status_nxt = ist_pkg::ST_FULL;
              end else begin
                alloc_nxt = 1'b1;
                state_nxt = S_SCAN;
                if (CMPW'(hint_r) >= CMPW'(SLOTS)) begin
                  wrapped_nxt = 1'b1;
                end else begin
                  st = CMPW'(hint_r);
                end
              end
            end
            ist_pkg::CMD_FREE: begin
              if (in_ch.handle_in == '0) begin
                res_status_nxt = ist_pkg::ST_OK;
              end else if (!h_in_range) begin
                res_status_nxt = ist_pkg::ST_RANGE;
              end else if (!h_hit) begin
                res_status_nxt = ist_pkg::ST_EMPTY;
              end else begin
                valid_nxt[hidx] = 1'b0;
                cnt_nxt         = cnt_r - 1'b1;
                if (NW'(hm1) < hint_r) begin
                  hint_nxt = NW'(hm1);
                end
                if (hext == hwext) begin
                  st        = CMPW'(hm1);
                  state_nxt = S_TRIM;
                end else begin
                  st        = hext;
                  state_nxt = S_SCAN;
                end
              end
            end
            ist_pkg::CMD_FIRST: begin
              if (cnt_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            ist_pkg::CMD_NEXT: begin
              if ((in_ch.handle_in != '0) && (hext < CMPW'(SLOTS))) begin
                st        = hext;
                state_nxt = S_SCAN;
              end
            end
            ist_pkg::CMD_READ: begin
              if (!h_in_range) begin
                res_status_nxt = ist_pkg::ST_RANGE;
              end else if (!h_hit) begin
                res_status_nxt = ist_pkg::ST_EMPTY;
              end else begin
                res_dvalid_nxt = 1'b1;
                rd_en          = 1'b1;
              end
            end
            default: begin
              res_status_nxt = ist_pkg::ST_OK;
            end
          endcase
          chunk_nxt = CW'(st >> ist_pkg::CHUNK_W);
          bound_nxt = NW'(st);
        end
      end

      S_SCAN: begin
        if (scan_rsp.found) begin
          res_hout_nxt = ist_pkg::HANDLE_W'(fnext);
          state_nxt    = S_EMIT;
          if (alloc_r) begin
            wr_en               = 1'b1;
            valid_nxt[fidx[SW-1:0]] = 1'b1;
            cnt_nxt             = cnt_r + 1'b1;
            hint_nxt            = fnext_nw;
            if (fnext_nw > hw_r) begin
              hw_nxt = fnext_nw;
            end
          end
        end else if (chunk_r == CW'(NCHUNK - 1)) begin
          if (alloc_r && !wrapped_r) begin
            wrapped_nxt = 1'b1;
            chunk_nxt   = '0;
            bound_nxt   = '0;
          end else begin
            if (alloc_r) begin
              res_status_nxt = ist_pkg::ST_FULL;
            end
            state_nxt = S_EMIT;
          end
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end

      S_TRIM: begin
        if (scan_rsp.found) begin
          hw_nxt    = fnext_nw;
          state_nxt = S_EMIT;
        end else if (chunk_r == '0) begin
          hw_nxt    = '0;
          state_nxt = S_EMIT;
        end else begin
          chunk_nxt = chunk_r - 1'b1;
        end
      end

      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      hint_r      <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      hint_r      <= hint_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alloc_r      <= alloc_nxt;
    wrapped_r    <= wrapped_nxt;
    chunk_r      <= chunk_nxt;
    bound_r      <= bound_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_hout_r   <= res_hout_nxt;
    res_dvalid_r <= res_dvalid_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_hout_r   <= res_hout_r;
      out_data_r   <= res_dvalid_r ? ist_pkg::DATA_W'(rd_word_r) : '0;
      out_dvalid_r <= res_dvalid_r;
      out_cnt_r    <= ist_pkg::COUNT_W'(cnt_r);
    end
  end

  // Word store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_addr] <= value_r;
    end
    if (rd_en) begin
      rd_word_r <= words[hidx];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(SLOTS))
    else $error("occupied count above capacity");

  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("occupied count differs from valid bits");

  a_hw_above: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r >> hw_r) == '0)
    else $error("occupied slot at or above high-water mark");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer idle right after a request");
`endif

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the indexed slot table with burst driver and stalling receiver.
module tb;
  import ist_pkg::*;

  localparam int TBL_SLOTS = 64;
  localparam int RAND_REQS = 1650;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] handle;
    logic [DATA_W-1:0]   value;
  } slot_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [DATA_W-1:0]   data;
    logic                data_valid;
    logic [COUNT_W-1:0]  used;
  } slot_rsp_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic clk = 1'b0;
  logic rst_n;

  ist_in_if  in_ch();
  ist_out_if out_ch();

  indexed_slot_table #(.SLOTS(TBL_SLOTS), .WORD_BITS(DATA_W)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  slot_req_t req_q[$];
  slot_rsp_t rsp_q[$];
  int        fail_cnt = 0;

  // predicted table state
  logic [DATA_W-1:0]    tbl_word [TBL_SLOTS];
  logic [TBL_SLOTS-1:0] tbl_used = '0;
  int                   tbl_count = 0;
  int                   tbl_hint = 0;
  int                   tbl_mark = 0;

  // occupancy as seen by the request generator
  logic [TBL_SLOTS-1:0] gen_occ = '0;

  function automatic int next_held(int start);
    int i;
    for (i = start; i < tbl_mark && i < TBL_SLOTS; i++)
      if (tbl_used[i]) return i + 1;
    return 0;
  endfunction

  function automatic void predict_table(slot_req_t r);
    slot_rsp_t e;
    int        h;
    int        idx;
    int        i;
    e = '{default: '0};
    h = r.handle;
    case (r.command)
      CMD_ALLOC: begin
        idx = -1;
        if (tbl_count < TBL_SLOTS) begin
          for (i = tbl_hint; i < TBL_SLOTS && idx < 0; i++)
            if (!tbl_used[i]) idx = i;
          for (i = 0; i < TBL_SLOTS && idx < 0; i++)
            if (!tbl_used[i]) idx = i;
        end
        if (idx < 0) begin
          e.status = ST_FULL;
        end else begin
          tbl_used[idx] = 1'b1;
          tbl_word[idx] = r.value;
          tbl_count++;
          tbl_hint = idx + 1;
          if (idx + 1 > tbl_mark) tbl_mark = idx + 1;
          e.handle = HANDLE_W'(idx + 1);
        end
      end
      CMD_FREE: begin
        if (h != 0) begin
          idx = h - 1;
          if (idx >= tbl_mark || idx >= TBL_SLOTS) begin
            e.status = ST_RANGE;
          end else if (!tbl_used[idx]) begin
            e.status = ST_EMPTY;
          end else begin
            tbl_used[idx] = 1'b0;
            tbl_count--;
            if (idx < tbl_hint) tbl_hint = idx;
            if (idx + 1 == tbl_mark)
              while (tbl_mark > 0 && !tbl_used[tbl_mark-1]) tbl_mark--;
            e.handle = HANDLE_W'(next_held(idx + 1));
          end
        end
      end
      CMD_FIRST: begin
        if (tbl_count != 0) e.handle = HANDLE_W'(next_held(0));
      end
      CMD_NEXT: begin
        if (h != 0) e.handle = HANDLE_W'(next_held(h));
      end
      CMD_READ: begin
        if (h == 0 || h - 1 >= tbl_mark || h - 1 >= TBL_SLOTS) begin
          e.status = ST_RANGE;
        end else if (!tbl_used[h-1]) begin
          e.status = ST_EMPTY;
        end else begin
          e.data       = tbl_word[h-1];
          e.data_valid = 1'b1;
        end
      end
      default: ;
    endcase
    e.used = COUNT_W'(tbl_count);
    rsp_q.push_back(e);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic int pick_held();
    int s;
    int k;
    s = $urandom_range(0, TBL_SLOTS - 1);
    for (k = 0; k < TBL_SLOTS; k++)
      if (gen_occ[(s + k) % TBL_SLOTS]) return (s + k) % TBL_SLOTS + 1;
    return 0;
  endfunction

  task automatic add_req(logic [CMD_W-1:0] cmd, int h, logic [DATA_W-1:0] v);
    slot_req_t r;
    int        i;
    logic      done;
    r.command = cmd;
    r.handle  = HANDLE_W'(h);
    r.value   = v;
    req_q.push_back(r);
    done = 1'b0;
    if (cmd == CMD_ALLOC) begin
      for (i = 0; i < TBL_SLOTS && !done; i++)
        if (!gen_occ[i]) begin
          gen_occ[i] = 1'b1;
          done = 1'b1;
        end
    end else if (cmd == CMD_FREE && h >= 1 && h <= TBL_SLOTS) begin
      gen_occ[h-1] = 1'b0;
    end
  endtask

  // request driver: bursts with random gaps
  int        burst_cnt = 0;
  int        gap_cnt = 0;
  slot_req_t drv_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_table(req_q.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_ch.valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          drv_req = req_q[0];
          in_ch.valid     <= 1'b1;
          in_ch.command   <= drv_req.command;
          in_ch.handle_in <= drv_req.handle;
          in_ch.value_in  <= drv_req.value;
          if (burst_cnt == 0) begin
            burst_cnt = $urandom_range(1, 40);
            gap_cnt   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_cnt--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern is chosen at random from four modes
  logic [1:0] rdy_mode = 2'd0;
  int         rdy_cyc = 0;

  always @(posedge clk) begin
    rdy_cyc++;
    if (rdy_cyc % 200 == 0) rdy_mode <= 2'($urandom_range(0, 3));
    case (rdy_mode)
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ch.ready <= (rdy_cyc % 4 == 0);
      default: out_ch.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  slot_rsp_t mon_want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rsp_q.size() == 0) begin
        $error("result with no request pending: handle_out 0x%0h", out_ch.handle_out);
        fail_cnt++;
      end else begin
        mon_want = rsp_q.pop_front();
        check_field("status", mon_want.status, out_ch.status);
        check_field("handle_out", mon_want.handle, out_ch.handle_out);
        check_field("data_out", mon_want.data, out_ch.data_out);
        check_field("data_valid", mon_want.data_valid, out_ch.data_valid);
        check_field("used_count", mon_want.used, out_ch.used_count);
      end
    end
  end

  initial begin
    phase_t            ph;
    int                ph_len;
    int                n_rand;
    int                sel;
    int                h;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] v;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = '0;
    in_ch.handle_in = '0;
    in_ch.value_in  = '0;
    out_ch.ready    = 1'b0;

    // directed corner cases on an empty table, then a short table
    add_req(CMD_FIRST, 0, '0);
    add_req(CMD_READ, 0, '0);
    add_req(CMD_FREE, 0, '0);
    add_req(CMD_FREE, 64, '0);
    add_req(CMD_NEXT, 0, '0);
    add_req(CMD_ALLOC, 0, 32'h0000_0000);
    add_req(CMD_ALLOC, 0, 32'hFFFF_FFFF);
    add_req(CMD_ALLOC, 0, 32'hA5A5_5A5A);
    add_req(CMD_READ, 1, '0);
    add_req(CMD_READ, 2, '0);
    add_req(CMD_READ, 64, '0);
    add_req(CMD_FIRST, 0, '0);
    add_req(CMD_NEXT, 1, '0);
    add_req(CMD_NEXT, 3, '0);
    add_req(CMD_NEXT, 64, '0);
    add_req(CMD_FREE, 2, '0);
    add_req(CMD_FREE, 2, '0);
    add_req(CMD_READ, 2, '0);
    add_req(CMD_ALLOC, 0, 32'h1234_5678);
    add_req(3'd5, 64, 32'hFFFF_FFFF);
    add_req(3'd6, 1, '0);
    add_req(3'd7, 0, 32'h5A5A_A5A5);
    add_req(CMD_FREE, 3, '0);
    add_req(CMD_FREE, 3, '0);
    add_req(CMD_READ, 3, '0);

    n_rand = 0;
    while (n_rand < RAND_REQS) begin
      sel = $urandom_range(0, 2);
      ph = (sel == 0) ? PH_FILL : (sel == 1) ? PH_DRAIN : PH_MIX;
      ph_len = $urandom_range(40, 150);
      for (int k = 0; k < ph_len; k++) begin
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       v = '0;
          1:       v = '1;
          default: v = $urandom;
        endcase
        h = ($urandom_range(0, 3) != 0) ? pick_held() : $urandom_range(0, 64);
        if (ph == PH_FILL) begin
          cmd = (sel < 85) ? CMD_ALLOC : CMD_W'($urandom_range(CMD_FREE, CMD_READ));
        end else if (ph == PH_DRAIN) begin
          if (sel < 75) cmd = CMD_FREE;
          else if (sel < 80) cmd = CMD_ALLOC;
          else cmd = CMD_W'($urandom_range(CMD_FIRST, CMD_READ));
        end else begin
          cmd = (sel < 5) ? CMD_W'($urandom_range(5, 7))
                          : CMD_W'($urandom_range(CMD_ALLOC, CMD_READ));
        end
        if (cmd == CMD_FREE && ph != PH_MIX && $urandom_range(0, 9) == 0)
          h = $urandom_range(0, 64);
        add_req(cmd, h, v);
        n_rand++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || rsp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
